[src/mpe_pkg.sv]
// Shared types and constants for the mono to 4bpp palette expander.
// Used by the front end, the job queue, the back end and the top level.
// No dependencies.
package mpe_pkg;

  // Largest row the expander handles, in pixels.
  localparam int unsigned MaxWidth = 4096;

  // Width of the row_width configuration field.
  localparam int unsigned RowWidthW = 13;

  // Configuration register indexes.
  localparam logic [1:0] CfgBackground = 2'd0;
  localparam logic [1:0] CfgForeground = 2'd1;
  localparam logic [1:0] CfgRowWidth   = 2'd2;

  // Column counter width; at least one bit is left above the byte offset.
  localparam int unsigned ColW = ($clog2(MaxWidth) > 3) ? $clog2(MaxWidth) : 4;

  // The column always advances a whole source byte at a time, so only the
  // byte number is stored.
  localparam int unsigned ColByteW = ColW - 3;

  // Width used for column and row width compares.
  localparam int unsigned CmpW = ((ColW > RowWidthW) ? ColW : RowWidthW) + 1;

  // Pixel count of one job, 1 to 8.
  localparam int unsigned PixCntW = 4;

  // Results per job, 0 to 4.
  localparam int unsigned ResCntW = 3;

  // Job queue between the front and the back end.
  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef logic [3:0] cidx_t;

  // One classified source byte.
  typedef struct packed {
    logic [7:0]         src;
    logic [PixCntW-1:0] npix;
    logic               row_end;
  } job_t;

endpackage

[src/mpe_front.sv]
// Front end of the expander: tracks the column and turns each source byte
// into a job (pixel count and row end flag). Depends on mpe_pkg.
module mpe_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [7:0]                  source_byte_i,
  input  logic [mpe_pkg::CmpW-1:0]    width_i,
  output mpe_pkg::job_t               job_o
);

  logic [mpe_pkg::ColByteW-1:0] col_q, col_d;
  logic [mpe_pkg::CmpW-1:0]     col_ext;
  logic [mpe_pkg::CmpW-1:0]     col_p8;
  logic [mpe_pkg::CmpW-1:0]     diff;
  logic                         row_done;
  logic                         past_end;

  assign col_ext  = mpe_pkg::CmpW'({col_q, 3'b000});
  assign col_p8   = col_ext + mpe_pkg::CmpW'(8);
  assign diff     = width_i - col_ext;
  assign row_done = (col_p8 >= width_i);
  // The width may have been lowered below the column; one pixel still goes out.
  assign past_end = (col_ext >= width_i);

  always_comb begin
    job_o.src     = source_byte_i;
    job_o.row_end = row_done;
    if (!row_done) begin
      job_o.npix = mpe_pkg::PixCntW'(8);
    end else if (past_end) begin
      job_o.npix = mpe_pkg::PixCntW'(1);
    end else begin
      job_o.npix = diff[mpe_pkg::PixCntW-1:0];
    end
  end

  always_comb begin
    col_d = col_q;
    if (accept_i) begin
      col_d = row_done ? '0 : col_p8[mpe_pkg::ColW-1:3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  a_npix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |-> (job_o.npix != '0) && (job_o.npix <= mpe_pkg::PixCntW'(8)))
    else $error("job pixel count out of range");

  a_short_job_ends_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && (job_o.npix != mpe_pkg::PixCntW'(8))) |=> (col_q == '0))
    else $error("short job did not restart the row");

endmodule

[src/mpe_fifo.sv]
// Short job queue between the front and the back end of the expander.
// Depends on mpe_pkg for the job type and depth.
module mpe_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mpe_pkg::job_t push_data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output mpe_pkg::job_t data_o
);

  mpe_pkg::job_t                 mem_q [mpe_pkg::FifoDepth];
  logic [mpe_pkg::FifoPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [mpe_pkg::FifoPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [mpe_pkg::FifoCntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == mpe_pkg::FifoCntW'(mpe_pkg::FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  function automatic logic [mpe_pkg::FifoPtrW-1:0] ptr_inc(
    input logic [mpe_pkg::FifoPtrW-1:0] p
  );
    if (p == mpe_pkg::FifoPtrW'(mpe_pkg::FifoDepth - 1)) begin
      return '0;
    end
    return p + mpe_pkg::FifoPtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + mpe_pkg::FifoCntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - mpe_pkg::FifoCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("job queue underflow");

endmodule

[src/mpe_back.sv]
// Back end of the expander: walks one job a result at a time, maps pixels
// to colour indices and holds the result in an output register.
// Depends on mpe_pkg.
module mpe_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  mpe_pkg::job_t job_i,
  output logic          job_pop_o,
  input  mpe_pkg::cidx_t bg_idx_i,
  input  mpe_pkg::cidx_t fg_idx_i,
  output logic          empty_o,
  input  logic          pop_i,
  output logic [7:0]    packed_byte_o,
  output logic          row_end_o,
  output logic          last_of_run_o
);

  logic [1:0]                  slot_q, slot_d;
  logic                        out_valid_q, out_valid_d;
  logic [7:0]                  packed_q;
  logic                        row_end_q;
  logic                        last_q;
  logic [mpe_pkg::ResCntW-1:0] nres;
  logic                        last_slot;
  logic                        advance;
  logic                        load;
  logic [7:0]                  shifted;
  logic                        lo_used;
  mpe_pkg::cidx_t              hi_nib;
  mpe_pkg::cidx_t              lo_nib;

  // A job ending on an odd pixel count adds one half-filled byte.
  assign nres = mpe_pkg::ResCntW'(job_i.npix[mpe_pkg::PixCntW-1:1])
              + mpe_pkg::ResCntW'(job_i.npix[0] & job_i.row_end);
  assign last_slot = (mpe_pkg::ResCntW'(slot_q) == nres - mpe_pkg::ResCntW'(1));
  assign advance   = !out_valid_q || pop_i;

  assign shifted = job_i.src << {slot_q, 1'b0};
  assign lo_used = (mpe_pkg::PixCntW'({slot_q, 1'b1}) < job_i.npix);
  assign hi_nib  = shifted[7] ? fg_idx_i : bg_idx_i;
  assign lo_nib  = !lo_used ? '0 : (shifted[6] ? fg_idx_i : bg_idx_i);

  always_comb begin
    job_pop_o = 1'b0;
    load      = 1'b0;
    slot_d    = slot_q;
    if (advance && job_valid_i) begin
      if (nres == '0) begin
        job_pop_o = 1'b1;
      end else begin
        load = 1'b1;
        if (last_slot) begin
          job_pop_o = 1'b1;
          slot_d    = '0;
        end else begin
          slot_d = slot_q + 2'd1;
        end
      end
    end
    out_valid_d = load || (out_valid_q && !pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      packed_q  <= {hi_nib, lo_nib};
      row_end_q <= last_slot && job_i.row_end;
      last_q    <= last_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign empty_o       = !out_valid_q;
  assign packed_byte_o = packed_q;
  assign row_end_o     = row_end_q;
  assign last_of_run_o = last_q;

  a_row_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && row_end_o) |-> last_of_run_o)
    else $error("row end on a result that is not the last of its byte");

  a_slot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !job_valid_i |-> (slot_q == '0))
    else $error("result slot left mid-job with no job queued");

endmodule

[src/mono_to_4bpp_palette_expander_core.sv]
// Top level of the mono to 4bpp palette expander: configuration registers,
// colour index mapping, and the front end, job queue and back end.
// Depends on mpe_pkg, mpe_front, mpe_fifo and mpe_back.

// Each accepted source byte of eight one-bit pixels (most significant bit
// first) becomes up to four output bytes of two 4-bit colour indices, the
// earlier pixel in the high nibble. A full byte makes four results, given
// one per cycle from the back end's output register while pop is held; a
// byte that ends a row makes one result per two pixels (ceil(pixels / 2)).
// A new byte is taken every cycle while the two-entry job queue has room, so
// input and output stall independently. A result passes through the job
// queue and then the back end's output register before it shows on the
// output. Colours map to an index when they are written; a zero row width
// acts as one and widths above the maximum saturate. Configuration writes
// are always ready and are meant for idle periods only.
module mono_to_4bpp_palette_expander_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  source_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  packed_byte_o,
  output logic        row_end_o,
  output logic        last_of_run_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  function automatic mpe_pkg::cidx_t colour_index(input logic [23:0] c);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       bright;
    r      = c[23:16];
    g      = c[15:8];
    b      = c[7:0];
    bright = (r > 8'hc0) || (g > 8'hc0) || (b > 8'hc0);
    unique case (c)
      24'h000000: return 4'd0;
      24'h800000: return 4'd1;
      24'h008000: return 4'd2;
      24'h808000: return 4'd3;
      24'h000080: return 4'd4;
      24'h800080: return 4'd5;
      24'h008080: return 4'd6;
      24'hc0c0c0: return 4'd7;
      24'h808080: return 4'd8;
      24'hff0000: return 4'd9;
      24'h00ff00: return 4'd10;
      24'hffff00: return 4'd11;
      24'h0000ff: return 4'd12;
      24'hff00ff: return 4'd13;
      24'h00ffff: return 4'd14;
      24'hffffff: return 4'd15;
      default:    return {bright, b[7], g[7], r[7]};
    endcase
  endfunction

  function automatic logic [mpe_pkg::CmpW-1:0] eff_width(
    input logic [mpe_pkg::RowWidthW-1:0] w
  );
    logic [mpe_pkg::CmpW-1:0] wx;
    wx = mpe_pkg::CmpW'(w);
    if (wx == '0) begin
      return mpe_pkg::CmpW'(1);
    end
    if (wx > mpe_pkg::CmpW'(mpe_pkg::MaxWidth)) begin
      return mpe_pkg::CmpW'(mpe_pkg::MaxWidth);
    end
    return wx;
  endfunction

  mpe_pkg::cidx_t           bg_idx_q, bg_idx_d;
  mpe_pkg::cidx_t           fg_idx_q, fg_idx_d;
  logic [mpe_pkg::CmpW-1:0] width_q, width_d;
  logic                     cfg_write;
  logic                     accept;
  mpe_pkg::job_t            new_job;
  mpe_pkg::job_t            head_job;
  logic                     head_valid;
  logic                     head_pop;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_comb begin
    bg_idx_d = bg_idx_q;
    fg_idx_d = fg_idx_q;
    width_d  = width_q;
    if (cfg_write) begin
      unique case (cfg_index_i)
        mpe_pkg::CfgBackground: bg_idx_d = colour_index(cfg_data_i);
        mpe_pkg::CfgForeground: fg_idx_d = colour_index(cfg_data_i);
        mpe_pkg::CfgRowWidth:
          width_d = eff_width(cfg_data_i[mpe_pkg::RowWidthW-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_idx_q <= 4'd0;
      fg_idx_q <= 4'd15;
      width_q  <= mpe_pkg::CmpW'(640);
    end else begin
      bg_idx_q <= bg_idx_d;
      fg_idx_q <= fg_idx_d;
      width_q  <= width_d;
    end
  end

  assign accept = push && !full;

  mpe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .source_byte_i (source_byte_i),
    .width_i       (width_q),
    .job_o         (new_job)
  );

  mpe_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (new_job),
    .full_o      (full),
    .valid_o     (head_valid),
    .pop_i       (head_pop),
    .data_o      (head_job)
  );

  mpe_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (head_valid),
    .job_i         (head_job),
    .job_pop_o     (head_pop),
    .bg_idx_i      (bg_idx_q),
    .fg_idx_i      (fg_idx_q),
    .empty_o       (empty),
    .pop_i         (pop),
    .packed_byte_o (packed_byte_o),
    .row_end_o     (row_end_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

[tb/tb.sv]
// Self-checking testbench for mono_to_4bpp_palette_expander_core: directed rows, then
// random phases of register writes and source bytes, with each result checked against
// typed values or a local model. Depends on mpe_pkg and the expander RTL.
module tb;

  localparam logic [1:0] REG_BG    = mpe_pkg::CfgBackground;
  localparam logic [1:0] REG_FG    = mpe_pkg::CfgForeground;
  localparam logic [1:0] REG_WIDTH = mpe_pkg::CfgRowWidth;
  // Index 3 decodes to no register, so a write there must change nothing.
  localparam logic [1:0] REG_NONE  = 2'd3;

  localparam int RAND_ITEMS   = 360;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [16*24-1:0] EXACT_COLOURS = {
    24'h000000, 24'h800000, 24'h008000, 24'h808000, 24'h000080, 24'h800080,
    24'h008080, 24'hc0c0c0, 24'h808080, 24'hff0000, 24'h00ff00, 24'hffff00,
    24'h0000ff, 24'hff00ff, 24'h00ffff, 24'hffffff};

  typedef struct packed {
    logic [7:0] packed_byte;
    logic       row_end;
    logic       last_of_run;
  } pixel_pair_t;

  typedef enum logic [0:0] {ROW_CFG, ROW_DATA} row_kind_e;

  // A directed row: either a register write or a source byte. A byte with
  // n_typed above zero carries its results typed in (first result in the top byte
  // of pk and the top bit of re); otherwise the model supplies them.
  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  idx;
    logic [23:0] data;
    logic [7:0]  src;
    logic [2:0]  n_typed;
    logic [31:0] pk;
    logic [3:0]  re;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  source_byte_i;
  logic        empty;
  logic        pop;
  logic [7:0]  packed_byte_o;
  logic        row_end_o;
  logic        last_of_run_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [23:0] cfg_data_i;

  // Model state and registers.
  mpe_pkg::cidx_t bg_idx;
  mpe_pkg::cidx_t fg_idx;
  logic [12:0]    width_reg;
  logic [12:0]    pred_col;
  mpe_pkg::cidx_t pred_held;
  pixel_pair_t    step_res [4];
  int             step_n;

  pixel_pair_t pending_pairs [$];
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  bit          send_burst;
  bit          recv_burst;

  mono_to_4bpp_palette_expander_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .source_byte_i (source_byte_i),
    .empty         (empty),
    .pop           (pop),
    .packed_byte_o (packed_byte_o),
    .row_end_o     (row_end_o),
    .last_of_run_o (last_of_run_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic mpe_pkg::cidx_t colour_to_index(input logic [23:0] c);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] bl;
    r  = c[23:16];
    g  = c[15:8];
    bl = c[7:0];
    case (c)
      24'h000000: return 4'd0;
      24'h800000: return 4'd1;
      24'h008000: return 4'd2;
      24'h808000: return 4'd3;
      24'h000080: return 4'd4;
      24'h800080: return 4'd5;
      24'h008080: return 4'd6;
      24'hc0c0c0: return 4'd7;
      24'h808080: return 4'd8;
      24'hff0000: return 4'd9;
      24'h00ff00: return 4'd10;
      24'hffff00: return 4'd11;
      24'h0000ff: return 4'd12;
      24'hff00ff: return 4'd13;
      24'h00ffff: return 4'd14;
      24'hffffff: return 4'd15;
      default:    return {(r > 8'hc0) || (g > 8'hc0) || (bl > 8'hc0), bl[7], g[7], r[7]};
    endcase
  endfunction

  // Expands one accepted source byte into step_res[0 .. step_n-1].
  task automatic expand_byte(input logic [7:0] src);
    logic [12:0]    eff_w;
    mpe_pkg::cidx_t idx;
    logic           odd;
    logic           at_end;
    logic           done;
    int             b;
    step_n = 0;
    done   = 1'b0;
    if (width_reg == 13'd0) eff_w = 13'd1;
    else if (width_reg > mpe_pkg::MaxWidth) eff_w = 13'(mpe_pkg::MaxWidth);
    else eff_w = width_reg;
    for (b = 7; b >= 0; b--) begin
      if (!done) begin
        idx      = src[b] ? fg_idx : bg_idx;
        odd      = pred_col[0];
        pred_col = pred_col + 13'd1;
        at_end   = (pred_col >= eff_w);
        if (odd || at_end) begin
          // An even pixel that ends the row goes out alone in the high nibble.
          step_res[step_n] = '{odd ? {pred_held, idx} : {idx, 4'h0}, at_end, 1'b0};
          step_n++;
        end
        if (!odd) pred_held = idx;
        if (at_end) begin
          pred_col = 13'd0;
          done     = 1'b1;
        end
      end
    end
    if (step_n > 0) step_res[step_n - 1].last_of_run = 1'b1;
  endtask

  function automatic int pick_gap(input bit burst);
    int k;
    if (burst) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 90) return $urandom_range(1, 3);
    if (k < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] edge_channel();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'h7f;
      2:       return 8'h80;
      3:       return 8'hc0;
      4:       return 8'hc1;
      default: return 8'hff;
    endcase
  endfunction

  function automatic logic [23:0] pick_colour();
    int k;
    k = $urandom_range(0, 2);
    if (k == 0) return EXACT_COLOURS[$urandom_range(0, 15) * 24 +: 24];
    if (k == 1) return {edge_channel(), edge_channel(), edge_channel()};
    return 24'($urandom);
  endfunction

  // Upper data bits are random so that the 13-bit field width is exercised too.
  function automatic logic [23:0] pick_width();
    int          k;
    logic [12:0] w;
    logic [10:0] junk;
    k    = $urandom_range(0, 99);
    junk = 11'($urandom);
    if (k < 70) w = 13'($urandom_range(1, 24));
    else if (k < 80) w = 13'($urandom_range(25, 200));
    else if (k < 88) w = 13'd640;
    else if (k < 92) w = 13'd0;
    else if (k < 96) w = 13'(mpe_pkg::MaxWidth);
    else w = 13'($urandom_range(mpe_pkg::MaxWidth + 1, 8191));
    return {junk, w};
  endfunction

  function automatic dir_row_t data_row(input logic [7:0] src, input logic [2:0] n,
                                        input logic [31:0] pk, input logic [3:0] re);
    return '{ROW_DATA, 2'd0, 24'd0, src, n, pk, re};
  endfunction

  function automatic dir_row_t cfg_row(input logic [1:0] idx, input logic [23:0] data);
    return '{ROW_CFG, idx, data, 8'd0, 3'd0, 32'd0, 4'd0};
  endfunction

  task automatic send_byte(input logic [7:0] src, input int gap, input logic [2:0] n_typed,
                           input logic [31:0] pk, input logic [3:0] re);
    int i;
    if (gap > 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push          <= 1'b1;
    source_byte_i <= src;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    expand_byte(src);
    if (n_typed == 3'd0) begin
      for (i = 0; i < step_n; i++) pending_pairs.push_back(step_res[i]);
    end else begin
      for (i = 0; i < n_typed; i++)
        pending_pairs.push_back('{pk[31 - 8 * i -: 8], re[3 - i], i == n_typed - 1});
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_BG:    bg_idx = colour_to_index(data);
      REG_FG:    fg_idx = colour_to_index(data);
      REG_WIDTH: width_reg = data[12:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Stops the sender and waits until the block has nothing left in flight.
  task automatic drain_results();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : result_sink
    int          gap;
    pixel_pair_t got;
    pixel_pair_t want;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      gap = pick_gap(recv_burst);
      if (gap > 0) begin
        @(negedge clk_i);
        pop <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      got = '{packed_byte_o, row_end_o, last_of_run_o};
      if (pending_pairs.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result: byte %h row_end %b last %b",
                   got.packed_byte, got.row_end, got.last_of_run);
      end else begin
        want = pending_pairs.pop_front();
        if (got !== want) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch: expected %h re %b last %b, got %h re %b last %b",
                     want.packed_byte, want.row_end, want.last_of_run,
                     got.packed_byte, got.row_end, got.last_of_run);
        end
      end
    end
  end

  initial begin : stimulus
    dir_row_t dir_rows [$];
    int       rand_sent;
    int       nitems;
    int       k;
    int       r;
    logic [7:0] src;
    push          = 1'b0;
    source_byte_i = 8'd0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = 2'd0;
    cfg_data_i    = 24'd0;
    rst_ni        = 1'b0;
    send_burst    = 1'b0;
    recv_burst    = 1'b0;
    bg_idx        = colour_to_index(24'h000000);
    fg_idx        = colour_to_index(24'hffffff);
    width_reg     = 13'd640;
    pred_col      = 13'd0;
    pred_held     = 4'd0;

    // Reset colours: clear bits map to index 0, set bits to index 15.
    dir_rows.push_back(data_row(8'h00, 3'd4, 32'h00000000, 4'b0000));
    dir_rows.push_back(data_row(8'hff, 3'd4, 32'hffffffff, 4'b0000));
    dir_rows.push_back(data_row(8'ha5, 3'd4, 32'hf0f00f0f, 4'b0000));
    // Width lowered below the current column: one pixel, then the row ends.
    dir_rows.push_back(cfg_row(REG_WIDTH, 24'd1));
    dir_rows.push_back(data_row(8'h80, 3'd1, 32'hf0000000, 4'b1000));
    dir_rows.push_back(data_row(8'h7f, 3'd1, 32'h00000000, 4'b1000));
    // A zero width behaves as one pixel.
    dir_rows.push_back(cfg_row(REG_WIDTH, 24'd0));
    dir_rows.push_back(data_row(8'hff, 3'd1, 32'hf0000000, 4'b1000));
    // Largest field value saturates to the maximum row.
    dir_rows.push_back(cfg_row(REG_WIDTH, 24'h001fff));
    dir_rows.push_back(data_row(8'h3c, 3'd4, 32'h00ffff00, 4'b0000));
    dir_rows.push_back(cfg_row(REG_WIDTH, 24'd3));
    dir_rows.push_back(data_row(8'hc3, 3'd1, 32'hf0000000, 4'b1000));
    dir_rows.push_back(data_row(8'he0, 3'd2, 32'hfff00000, 4'b0100));
    dir_rows.push_back(cfg_row(REG_WIDTH, 24'd2));
    dir_rows.push_back(data_row(8'h40, 3'd1, 32'h0f000000, 4'b1000));
    dir_rows.push_back(cfg_row(REG_BG, 24'hff0000));
    dir_rows.push_back(cfg_row(REG_FG, 24'h00ffff));
    dir_rows.push_back(cfg_row(REG_WIDTH, 24'd16));
    dir_rows.push_back(data_row(8'h55, 3'd4, 32'h9e9e9e9e, 4'b0000));
    dir_rows.push_back(data_row(8'h0f, 3'd4, 32'h9999eeee, 4'b0001));
    // Thresholded colours and an odd row width; these rows use the model.
    dir_rows.push_back(cfg_row(REG_NONE, 24'habcdef));
    dir_rows.push_back(cfg_row(REG_BG, 24'hc0c0c1));
    dir_rows.push_back(cfg_row(REG_FG, 24'h7f8081));
    dir_rows.push_back(cfg_row(REG_WIDTH, 24'd7));
    dir_rows.push_back(data_row(8'h96, 3'd0, 32'd0, 4'd0));
    dir_rows.push_back(cfg_row(REG_BG, 24'hc0c0c0));
    dir_rows.push_back(cfg_row(REG_FG, 24'h808080));
    dir_rows.push_back(cfg_row(REG_WIDTH, 24'h0e0005));
    dir_rows.push_back(data_row(8'h5a, 3'd0, 32'd0, 4'd0));
    dir_rows.push_back(data_row(8'hc3, 3'd0, 32'd0, 4'd0));
    dir_rows.push_back(cfg_row(REG_BG, 24'hffffff));
    dir_rows.push_back(cfg_row(REG_FG, 24'h000000));
    dir_rows.push_back(cfg_row(REG_WIDTH, 24'd640));
    dir_rows.push_back(data_row(8'h01, 3'd0, 32'd0, 4'd0));
    dir_rows.push_back(data_row(8'h80, 3'd0, 32'd0, 4'd0));
    dir_rows.push_back(data_row(8'hff, 3'd0, 32'd0, 4'd0));

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_byte(dir_rows[i].src, pick_gap(1'b0), dir_rows[i].n_typed,
                  dir_rows[i].pk, dir_rows[i].re);
      end
    end

    // Random phases. Each one starts from an idle block, so the column carried
    // over from the last phase may lie beyond a newly lowered width.
    rand_sent = 0;
    while (rand_sent < RAND_ITEMS) begin
      drain_results();
      send_burst = ($urandom_range(0, 3) == 0);
      recv_burst = ($urandom_range(0, 3) == 0);
      for (r = 0; r < 3; r++) begin
        if ($urandom_range(0, 1) == 1)
          write_reg(2'(r), (2'(r) == REG_WIDTH) ? pick_width() : pick_colour());
      end
      if ($urandom_range(0, 15) == 0) write_reg(REG_NONE, 24'($urandom));
      nitems = $urandom_range(6, 30);
      while (nitems > 0) begin
        k = $urandom_range(0, 99);
        if (k < 10) src = 8'h00;
        else if (k < 20) src = 8'hff;
        else src = 8'($urandom_range(0, 255));
        send_byte(src, pick_gap(send_burst), 3'd0, 32'd0, 4'd0);
        nitems--;
        rand_sent++;
      end
    end

    drain_results();
    if (fail_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

[filelist.f]
src/mpe_pkg.sv
src/mpe_front.sv
src/mpe_fifo.sv
src/mpe_back.sv
src/mono_to_4bpp_palette_expander_core.sv
tb/tb.sv
